/* src/binomial_checkpoint_scheduler_assert.svh */
// Assertion macros for the binomial checkpoint scheduler.
// Both forms sample at clk_i; BCS_ASSERT is disabled when rst_ni is low.
`ifndef BINOMIAL_CHECKPOINT_SCHEDULER_ASSERT_SVH
`define BINOMIAL_CHECKPOINT_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define BCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BCS_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BCS_ASSERT(lbl, prop, msg)
`define BCS_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

/* src/bcs_pkg.sv */
package bcs_pkg;

  // Datapath width of the shared multiply and divide unit.
  localparam int DW = 64;
  // Width of the small factor and of the divisor (reps + ds stays below 2**10).
  localparam int MW = 10;
  // Width of the repetition counter.
  localparam int REPS_W = 9;

  localparam logic [2:0] ACT_ADVANCE   = 3'd0;
  localparam logic [2:0] ACT_TAKESHOT  = 3'd1;
  localparam logic [2:0] ACT_RESTORE   = 3'd2;
  localparam logic [2:0] ACT_FIRSTURN  = 3'd3;
  localparam logic [2:0] ACT_YOUTURN   = 3'd4;
  localparam logic [2:0] ACT_TERMINATE = 3'd5;
  localparam logic [2:0] ACT_ERROR     = 3'd6;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_BAD_ARGS   = 3'd1;
  localparam logic [2:0] ERR_STORE_FULL = 3'd2;
  localparam logic [2:0] ERR_OVER_LIMIT = 3'd3;
  localparam logic [2:0] ERR_FINE_GREW  = 3'd4;
  localparam logic [2:0] ERR_LIMIT_BIG  = 3'd5;
  localparam logic [2:0] ERR_REPS_BOUND = 3'd6;

  localparam logic [1:0] REG_SNAPSHOT_LIMIT = 2'd0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_RD0,
    S_RD1,
    S_DEC,
    S_LOOP,
    S_POST,
    S_SETUP,
    S_MUL,
    S_DIV,
    S_STORE,
    S_FIN,
    S_DONE
  } state_e;

endpackage

/* src/binomial_checkpoint_scheduler.sv */
// Binomial checkpoint scheduler. Each request carries the current checkpoint
// index and the subrange of time steps still to be reversed, and the block
// answers with exactly one result transfer: the next action (advance, take
// snapshot, restore, first turn, turn, terminate or error), the updated index
// and subrange, and an error code. Requests are handled one at a time; in_ready_o
// is high only while the block is idle, and a finished result waits in an output
// register so the next request can be taken before the result is collected.
// Terminate, restore, turn and snapshot requests go from the check state through
// the memory read and decode states to the hand-off state. An advance request runs
// the binomial repetition loop and six more quotients on one shared shift-add
// multiplier and restoring divider; reps, the loop count, is at most
// MAX_REPEATS + 1. The snapshot limit is register 0 of the APB port; the user
// must write it only while the block is idle, and the block itself does not
// enforce this.
module binomial_checkpoint_scheduler import bcs_pkg::*; #(
  parameter int CHECKPOINT_DEPTH = 64,
  parameter int MAX_REPEATS      = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [7:0]  check_in_i,
  input  logic signed [31:0] capo_in_i,
  input  logic signed [31:0] fine_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         action_o,
  output logic signed [7:0]  check_out_o,
  output logic signed [31:0] capo_out_o,
  output logic signed [31:0] fine_out_o,
  output logic [2:0]         error_code_o
);

  localparam int AW = (CHECKPOINT_DEPTH > 1) ? $clog2(CHECKPOINT_DEPTH) : 1;
  localparam logic [REPS_W-1:0] MaxReps = REPS_W'(MAX_REPEATS);

  // Saved step of every checkpoint slot.
  logic [31:0] mem_q [CHECKPOINT_DEPTH];
  logic [31:0] mem_rdata_q;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata;

  state_e state_q, state_d;

  // Request being worked on.
  logic signed [7:0]  chk_q, chk_d;
  logic signed [31:0] capo_q, capo_d, fine_q, fine_d;
  logic [31:0]        s0_q, s0_d;

  // Schedule state kept between requests.
  logic               turn_seen_q, turn_seen_d;
  logic signed [31:0] prev_end_q, prev_end_d;
  logic [7:0]         prev_limit_q, prev_limit_d;
  logic [7:0]         snap_limit_q, snap_limit_d;

  // Repetition loop and stepsize variables.
  logic [REPS_W-1:0] reps_q, reps_d;
  logic [7:0]        ds_q, ds_d;
  logic [31:0]       len_q, len_d;
  logic [DW-1:0]     range_q, range_d;
  logic [DW-1:0]     b_q [6];
  logic [DW-1:0]     b_d [6];
  logic [2:0]        step_q, step_d;

  // Shared multiply and divide unit: acc = ma * mm, then acc = acc / md.
  logic [DW-1:0] ma_q, ma_d, acc_q, acc_d;
  logic [MW-1:0] mm_q, mm_d, md_q, md_d;
  logic [MW:0]   rem_q, rem_d;
  logic [6:0]    cnt_q, cnt_d;

  // Staged result and output register.
  logic [2:0]         res_act_q, res_act_d, res_err_q, res_err_d;
  logic signed [7:0]  res_chk_q, res_chk_d;
  logic signed [31:0] res_capo_q, res_capo_d, res_fine_q, res_fine_d;
  logic               out_valid_q, out_valid_d;
  logic [2:0]         act_q, act_d, err_q, err_d;
  logic signed [7:0]  chko_q, chko_d;
  logic signed [31:0] capoo_q, capoo_d, fineo_q, fineo_d;

  logic cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_SNAPSHOT_LIMIT);
  assign prdata = (paddr == REG_SNAPSHOT_LIMIT) ? {24'd0, snap_limit_q} : 32'd0;
  assign snap_limit_d = cfg_wr ? pwdata[7:0] : snap_limit_q;

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign action_o     = act_q;
  assign check_out_o  = chko_q;
  assign capo_out_o   = capoo_q;
  assign fine_out_o   = fineo_q;
  assign error_code_o = err_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  always_comb begin : seq
    logic signed [9:0]  chk10, chkp1, snaps10, ds10;
    logic signed [32:0] len33;
    logic               in_range;
    logic [31:0]        slot_val;
    logic [MW:0]        rdiv;
    logic               ge;
    logic [DW-1:0]      v;
    logic signed [63:0] capo64, fine64, nc;

    state_d      = state_q;
    chk_d        = chk_q;
    capo_d       = capo_q;
    fine_d       = fine_q;
    s0_d         = s0_q;
    turn_seen_d  = turn_seen_q;
    prev_end_d   = prev_end_q;
    prev_limit_d = prev_limit_q;
    reps_d       = reps_q;
    ds_d         = ds_q;
    len_d        = len_q;
    range_d      = range_q;
    b_d          = b_q;
    step_d       = step_q;
    ma_d         = ma_q;
    mm_d         = mm_q;
    md_d         = md_q;
    acc_d        = acc_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    res_act_d    = res_act_q;
    res_err_d    = ERR_NONE;
    res_chk_d    = chk_q;
    res_capo_d   = capo_q;
    res_fine_d   = fine_q;
    out_valid_d  = out_valid_q;
    act_d        = act_q;
    err_d        = err_q;
    chko_d       = chko_q;
    capoo_d      = capoo_q;
    fineo_d      = fineo_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_raddr    = '0;

    chk10    = 10'(chk_q);
    chkp1    = chk10 + 10'sd1;
    snaps10  = $signed({2'b00, snap_limit_q});
    ds10     = snaps10 - chk10;
    len33    = 33'(fine_q) - 33'(capo_q);
    in_range = (chk_q >= 0) && (int'(chk_q) < CHECKPOINT_DEPTH);
    slot_val = in_range ? mem_rdata_q : 32'd0;
    rdiv     = {rem_q[MW-1:0], acc_q[DW-1]};
    ge       = (rdiv >= {1'b0, md_q});
    v        = acc_q;
    capo64   = {{32{capo_q[31]}}, capo_q};
    fine64   = {{32{fine_q[31]}}, fine_q};
    nc       = capo64;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          chk_d   = check_in_i;
          capo_d  = capo_in_i;
          fine_d  = fine_in_i;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (chk_q < -8'sd1 || capo_q > fine_q) begin
          res_act_d = ACT_ERROR;
          res_err_d = ERR_BAD_ARGS;
          state_d   = S_DONE;
        end else begin
          // A fresh schedule parks slot 0 just before the start step.
          if (chk_q == -8'sd1 && capo_q < fine_q) begin
            turn_seen_d = 1'b0;
            mem_we      = 1'b1;
            mem_wdata   = capo_q - 32'sd1;
          end
          state_d = S_RD0;
        end
      end
      S_RD0: begin
        state_d = S_RD1;
      end
      S_RD1: begin
        s0_d      = mem_rdata_q;
        mem_raddr = chk_q[AW-1:0];
        state_d   = S_DEC;
      end
      S_DEC: begin
        len_d = len33[31:0];
        if (len33 == 33'sd0) begin
          if (chk_q == -8'sd1 || capo_q == $signed(s0_q)) begin
            res_act_d = ACT_TERMINATE;
            res_chk_d = chk_q - 8'sd1;
          end else begin
            res_act_d  = ACT_RESTORE;
            res_capo_d = $signed(slot_val);
            prev_end_d = fine_q;
          end
          state_d = S_DONE;
        end else if (len33 == 33'sd1) begin
          res_fine_d = fine_q - 32'sd1;
          prev_end_d = fine_q - 32'sd1;
          if (chk_q >= 0 && slot_val == capo_q) begin
            res_chk_d = chk_q - 8'sd1;
          end
          if (!turn_seen_q) begin
            turn_seen_d = 1'b1;
            res_act_d   = ACT_FIRSTURN;
          end else begin
            res_act_d = ACT_YOUTURN;
          end
          state_d = S_DONE;
        end else if (chk_q == -8'sd1 || slot_val != capo_q) begin
          res_chk_d = chkp1[7:0];
          state_d   = S_DONE;
          if (int'(chkp1) >= CHECKPOINT_DEPTH) begin
            res_act_d = ACT_ERROR;
            res_err_d = ERR_STORE_FULL;
          end else if (chkp1 + 10'sd1 > snaps10) begin
            res_act_d = ACT_ERROR;
            res_err_d = ERR_OVER_LIMIT;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = chkp1[AW-1:0];
            mem_wdata = capo_q;
            res_act_d = ACT_TAKESHOT;
            if (chkp1 == 10'sd0) begin
              prev_limit_d = snap_limit_q;
            end
            if (chkp1 == 10'sd0 && int'(snap_limit_q) > CHECKPOINT_DEPTH) begin
              res_act_d = ACT_ERROR;
              res_err_d = ERR_LIMIT_BIG;
            end else begin
              prev_end_d = fine_q;
            end
          end
        end else begin
          if (prev_end_q < fine_q && snaps10 == chkp1) begin
            res_act_d = ACT_ERROR;
            res_err_d = ERR_FINE_GREW;
            state_d   = S_DONE;
          end else if (ds10 < 10'sd1) begin
            res_act_d = ACT_ERROR;
            res_err_d = ERR_OVER_LIMIT;
            state_d   = S_DONE;
          end else begin
            ds_d    = ds10[7:0];
            reps_d  = '0;
            range_d = DW'(1);
            step_d  = '0;
            state_d = S_LOOP;
          end
        end
      end
      S_LOOP: begin
        // range = range * (reps + ds) / reps, with reps already advanced.
        if (range_q < DW'(len_q) && reps_q <= MaxReps) begin
          reps_d  = reps_q + REPS_W'(1);
          ma_d    = range_q;
          mm_d    = MW'(reps_q) + MW'(1) + MW'(ds_q);
          md_d    = MW'(reps_q) + MW'(1);
          acc_d   = '0;
          cnt_d   = '0;
          state_d = S_MUL;
        end else begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        if (reps_q > MaxReps) begin
          res_act_d = ACT_ERROR;
          res_err_d = ERR_REPS_BOUND;
          state_d   = S_DONE;
        end else if (snap_limit_q != prev_limit_q &&
                     int'(snap_limit_q) > CHECKPOINT_DEPTH) begin
          res_act_d = ACT_ERROR;
          res_err_d = ERR_LIMIT_BIG;
          state_d   = S_DONE;
        end else begin
          step_d  = 3'd1;
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        acc_d   = '0;
        cnt_d   = '0;
        state_d = S_MUL;
        unique case (step_q)
          3'd1: begin
            ma_d = range_q;
            mm_d = MW'(reps_q);
            md_d = MW'(ds_q) + MW'(reps_q);
          end
          3'd2: begin
            ma_d = b_q[0];
            mm_d = MW'(ds_q);
            md_d = MW'(ds_q) + MW'(reps_q) - MW'(1);
          end
          3'd3: begin
            ma_d = b_q[1];
            mm_d = MW'(ds_q) - MW'(1);
            md_d = MW'(ds_q) + MW'(reps_q) - MW'(2);
          end
          3'd4: begin
            ma_d = b_q[1];
            mm_d = MW'(reps_q) - MW'(1);
            md_d = MW'(ds_q);
          end
          3'd5: begin
            ma_d = b_q[2];
            mm_d = MW'(ds_q) - MW'(2);
            md_d = MW'(reps_q);
          end
          default: begin
            ma_d = b_q[0];
            mm_d = MW'(ds_q);
            md_d = MW'(reps_q);
          end
        endcase
      end
      S_MUL: begin
        if (mm_q[0]) begin
          acc_d = acc_q + ma_q;
        end
        ma_d  = ma_q << 1;
        mm_d  = mm_q >> 1;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(MW - 1)) begin
          cnt_d   = '0;
          rem_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        acc_d = {acc_q[DW-2:0], ge};
        rem_d = ge ? (rdiv - {1'b0, md_q}) : rdiv;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(DW - 1)) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        if (step_q == 3'd0) begin
          range_d = acc_q;
          state_d = S_LOOP;
        end else begin
          // Small snapshot counts replace some quotients by constants.
          if (step_q == 3'd2 && ds_q <= 8'd1) begin
            v = DW'(1);
          end else if (step_q == 3'd3 && ds_q == 8'd1) begin
            v = '0;
          end else if (step_q == 3'd3 && ds_q == 8'd2) begin
            v = DW'(1);
          end else if (step_q == 3'd5 && ds_q < 8'd3) begin
            v = '0;
          end else if (step_q == 3'd5 && ds_q == 8'd3) begin
            v = DW'(1);
          end
          b_d[step_q - 3'd1] = v;
          step_d  = step_q + 3'd1;
          state_d = (step_q == 3'd6) ? S_FIN : S_SETUP;
        end
      end
      S_FIN: begin
        priority if (DW'(len_q) <= b_q[0] + b_q[2]) begin
          nc = capo64 + $signed(b_q[3]);
        end else if (DW'(len_q) < b_q[0] + b_q[1]) begin
          nc = fine64 - $signed(b_q[1]) - $signed(b_q[2]);
        end else if (DW'(len_q) <= b_q[0] + b_q[1] + b_q[4]) begin
          nc = capo64 + $signed(b_q[0]) - $signed(b_q[2]);
        end else begin
          nc = fine64 - $signed(b_q[5]);
        end
        if (nc == capo64) begin
          nc = capo64 + 64'sd1;
        end
        res_capo_d = nc[31:0];
        res_act_d  = ACT_ADVANCE;
        prev_end_d = fine_q;
        state_d    = S_DONE;
      end
      S_DONE: begin
        res_err_d  = res_err_q;
        res_chk_d  = res_chk_q;
        res_capo_d = res_capo_q;
        res_fine_d = res_fine_q;
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          act_d       = res_act_q;
          err_d       = res_err_q;
          chko_d      = res_chk_q;
          capoo_d     = res_capo_q;
          fineo_d     = res_fine_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      turn_seen_q  <= 1'b0;
      prev_end_q   <= '0;
      prev_limit_q <= '0;
      snap_limit_q <= 8'd1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      turn_seen_q  <= turn_seen_d;
      prev_end_q   <= prev_end_d;
      prev_limit_q <= prev_limit_d;
      snap_limit_q <= snap_limit_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q      <= chk_d;
    capo_q     <= capo_d;
    fine_q     <= fine_d;
    s0_q       <= s0_d;
    reps_q     <= reps_d;
    ds_q       <= ds_d;
    len_q      <= len_d;
    range_q    <= range_d;
    b_q        <= b_d;
    step_q     <= step_d;
    ma_q       <= ma_d;
    mm_q       <= mm_d;
    md_q       <= md_d;
    acc_q      <= acc_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    res_act_q  <= res_act_d;
    res_err_q  <= res_err_d;
    res_chk_q  <= res_chk_d;
    res_capo_q <= res_capo_d;
    res_fine_q <= res_fine_d;
    act_q      <= act_d;
    err_q      <= err_d;
    chko_q     <= chko_d;
    capoo_q    <= capoo_d;
    fineo_q    <= fineo_d;
  end

`include "binomial_checkpoint_scheduler_assert.svh"

  // Only an error result carries a nonzero error code.
  `BCS_ASSERT(a_err_only_on_error, (out_valid_o && action_o != ACT_ERROR) |-> (error_code_o == ERR_NONE), "error code without error action")
  // A request transfer always leaves the block busy for the following cycle.
  `BCS_ASSERT(a_busy_after_req, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready right after a request transfer")
  // A result appears only from the hand-off state.
  `BCS_ASSERT(a_result_from_done, $rose(out_valid_o) |-> $past(state_q == S_DONE), "result raised outside hand-off")

endmodule
